// ===== rtl/pbs_pkg.sv =====
`timescale 1ns / 1ps

package pbs_pkg;

  // Period and converter geometry.
  localparam int SLOT_COUNT  = 20;
  localparam int SAMPLE_BITS = 10;

  // Field widths.
  localparam int SLOT_W    = 5;
  localparam int PCT_W     = 7;
  localparam int TENTH_W   = 4;
  localparam int ERR_W     = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Derived widths for the drive level and the band division.
  localparam int DRIVE_W = $clog2(SLOT_COUNT + 1);
  localparam int QUO_W   = $clog2(SLOT_COUNT);
  localparam int NUM_W   = CFG_W + QUO_W;

  // Scaling to tenths of a percent.
  localparam int TENTHS_SCALE = 1000;
  localparam int TENTHS_W     = 10;
  localparam int PROD_W       = SAMPLE_BITS + TENTHS_W;
  localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;

  // Division by ten as a reciprocal multiply, exact for inputs up to 1028.
  localparam int RECIP_10    = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int RECIP_W     = TENTHS_W + 8;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] SETPOINT_RESET   = CFG_W'(40);
  localparam logic [CFG_W-1:0] BAND_WIDTH_RESET = CFG_W'(30);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 2'd0,
    REG_BAND_WIDTH = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] setpoint;
    logic [CFG_W-1:0] band_width;
  } cfg_t;

  // One classified item as it waits for the slot sequencer.
  typedef struct packed {
    logic [PCT_W-1:0]          pct;
    logic [TENTH_W-1:0]        tenth;
    logic signed [ERR_W-1:0]   err;
    logic [DRIVE_W-1:0]        drive;
  } entry_t;

endpackage

// ===== rtl/proportional_band_slot_pwm_core.sv =====
`timescale 1ns / 1ps

// Proportional band controller with a time-proportioning slot output. Each
// sample accepted (start high while busy is low) produces twenty slot results
// on consecutive cycles, one per cycle, each marked by out_strobe; the
// receiver cannot hold them off, so it must take every strobed result. The
// slot sequencer takes a new sample only after the last slot of the current
// one, and when the next sample waits in the queue its results follow the
// last slot without a gap. A sample passes through an eleven-stage arithmetic
// pipeline (scaling, percent split, band classification and a
// one-bit-per-stage divider) into a two-entry queue and then into the slot
// sequencer registers behind the result ports. busy rises once two samples
// wait or are in flight, and falls again when the sequencer picks one up.
// Write setpoint and band_width through the cfg port only while no sample
// is pending.
module proportional_band_slot_pwm_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pbs_pkg::SAMPLE_BITS-1:0]      in_sample,
  output logic                                 out_strobe,
  output logic                                 out_slot_on,
  output logic [pbs_pkg::SLOT_W-1:0]           out_slot_index,
  output logic                                 out_last_slot,
  output logic [pbs_pkg::PCT_W-1:0]            out_level_percent,
  output logic [pbs_pkg::TENTH_W-1:0]          out_level_tenth,
  output logic signed [pbs_pkg::ERR_W-1:0]     out_control_error,
  input  logic                                 cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbs_pkg::CFG_W-1:0]            cfg_wdata
);

  pbs_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            push, pop, empty;
  pbs_pkg::entry_t push_data, pop_data;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pbs_pkg::REG_SETPOINT:   cfg_nxt.setpoint   = cfg_wdata;
        pbs_pkg::REG_BAND_WIDTH: cfg_nxt.band_width = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= pbs_pkg::SETPOINT_RESET;
      cfg_r.band_width <= pbs_pkg::BAND_WIDTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_sample (in_sample),
    .cfg       (cfg_r),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  pbs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  pbs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_strobe        (out_strobe),
    .out_slot_on       (out_slot_on),
    .out_slot_index    (out_slot_index),
    .out_last_slot     (out_last_slot),
    .out_level_percent (out_level_percent),
    .out_level_tenth   (out_level_tenth),
    .out_control_error (out_control_error)
  );

  // Within one item the slots run on without a gap, one index per cycle.
  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_slot |=>
      out_strobe && (out_slot_index == $past(out_slot_index) + pbs_pkg::SLOT_W'(1)))
    else $error("slot sequence broke inside an item");

  // Once a slot is off, every later slot of the same item is off.
  a_slot_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_slot && !out_slot_on |=> !out_slot_on)
    else $error("slot output turned on after an off slot");

  // The measured fields hold for the whole item.
  a_fields_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_slot |=>
      $stable(out_level_percent) && $stable(out_level_tenth) && $stable(out_control_error))
    else $error("item fields changed between slots");

endmodule

// ===== rtl/pbs_front.sv =====
`timescale 1ns / 1ps

module pbs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pbs_pkg::SAMPLE_BITS-1:0]      in_sample,
  input  pbs_pkg::cfg_t                        cfg,
  input  logic                                 pop,
  output logic                                 push,
  output pbs_pkg::entry_t                      push_data
);

  localparam int PROD_W   = pbs_pkg::PROD_W;
  localparam int TENTHS_W = pbs_pkg::TENTHS_W;
  localparam int PCT_W    = pbs_pkg::PCT_W;
  localparam int ERR_W    = pbs_pkg::ERR_W;
  localparam int CFG_W    = pbs_pkg::CFG_W;
  localparam int NUM_W    = pbs_pkg::NUM_W;
  localparam int QUO_W    = pbs_pkg::QUO_W;
  localparam int DRIVE_W  = pbs_pkg::DRIVE_W;
  localparam int SB       = pbs_pkg::SAMPLE_BITS;
  localparam int CNT_W    = pbs_pkg::CNT_W;

  // Items accepted and not yet taken from the queue by the back.
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             accept;

  assign busy   = (used_r == CNT_W'(pbs_pkg::FIFO_DEPTH));
  assign accept = start && !busy;

  always_comb begin
    used_nxt = used_r;
    if (accept && !pop) begin
      used_nxt = used_r + CNT_W'(1);
    end else if (!accept && pop) begin
      used_nxt = used_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Stage 1: sample times one thousand.
  logic              v1_r;
  logic [PROD_W-1:0] prod1_r;

  // Stage 2: quotient estimate of the division by full scale.
  logic                v2_r;
  logic [PROD_W-1:0]   prod2_r;
  logic [TENTHS_W-1:0] q0_2_r;
  logic [PROD_W:0]     est_sum;

  assign est_sum = (PROD_W+1)'(prod1_r) + (PROD_W+1)'(prod1_r >> SB);

  // Stage 3: one correction step gives the exact tenths.
  logic                v3_r;
  logic [TENTHS_W-1:0] ten3_r;
  logic [PROD_W-1:0]   rem3;

  assign rem3 = prod2_r - (PROD_W'(q0_2_r) << SB) + PROD_W'(q0_2_r);

  // Stage 4: whole percent by reciprocal multiply.
  logic                       v4_r;
  logic [TENTHS_W-1:0]        ten4_r;
  logic [PCT_W-1:0]           pct4_r;
  logic [pbs_pkg::RECIP_W-1:0] recip_prod;

  assign recip_prod = pbs_pkg::RECIP_W'(ten3_r) * pbs_pkg::RECIP_W'(pbs_pkg::RECIP_10);

  // Stage 5: tenths digit, error and band classification.
  logic                     v5_r;
  pbs_pkg::entry_t          meta5_r;
  logic                     lo5_r, hi5_r;
  logic [CFG_W-1:0]         off5_r;
  logic [TENTHS_W-1:0]      digit5;
  logic signed [ERR_W-1:0]  err5, half5, sum5;
  pbs_pkg::entry_t          meta5_nxt;

  always_comb begin
    digit5   = ten4_r - (TENTHS_W'(pct4_r) << 3) - (TENTHS_W'(pct4_r) << 1);
    err5     = $signed(ERR_W'(cfg.setpoint)) - $signed(ERR_W'(pct4_r));
    half5    = $signed(ERR_W'(cfg.band_width >> 1));
    sum5     = err5 + half5;
    meta5_nxt       = '0;
    meta5_nxt.pct   = pct4_r;
    meta5_nxt.tenth = pbs_pkg::TENTH_W'(digit5);
    meta5_nxt.err   = err5;
  end

  // Stage 6: numerator of the band division.
  logic             v6_r;
  pbs_pkg::entry_t  meta6_r;
  logic             lo6_r, hi6_r;
  logic [NUM_W-1:0] num6_r;

  // Restoring divider, one quotient bit per stage.
  logic [QUO_W-1:0]  dv_r;
  logic [NUM_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  pbs_pkg::entry_t   meta_r [QUO_W];
  logic [QUO_W-1:0]  lo_r, hi_r;

  logic [NUM_W-1:0]  rem_in  [QUO_W];
  logic [QUO_W-1:0]  quo_in  [QUO_W];
  logic [NUM_W-1:0]  rem_nxt [QUO_W];
  logic [QUO_W-1:0]  quo_nxt [QUO_W];
  logic [NUM_W-1:0]  dsr     [QUO_W];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_in[k] = (k == 0) ? num6_r : rem_r[(k == 0) ? 0 : k - 1];
      quo_in[k] = (k == 0) ? '0     : quo_r[(k == 0) ? 0 : k - 1];
      dsr[k]    = NUM_W'(cfg.band_width) << (QUO_W - 1 - k);
      quo_nxt[k] = quo_in[k];
      rem_nxt[k] = rem_in[k];
      if (rem_in[k] >= dsr[k]) begin
        rem_nxt[k] = rem_in[k] - dsr[k];
        quo_nxt[k][QUO_W-1-k] = 1'b1;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      dv_r <= '0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      for (int k = 0; k < QUO_W; k++) begin
        dv_r[k] <= (k == 0) ? v6_r : dv_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    prod1_r <= PROD_W'(in_sample) * PROD_W'(pbs_pkg::TENTHS_SCALE);
    prod2_r <= prod1_r;
    q0_2_r  <= TENTHS_W'(est_sum >> SB);
    ten3_r  <= q0_2_r + TENTHS_W'(rem3 >= PROD_W'(pbs_pkg::FULL_SCALE));
    ten4_r  <= ten3_r;
    pct4_r  <= PCT_W'(recip_prod >> pbs_pkg::RECIP_SHIFT);
    meta5_r <= meta5_nxt;
    lo5_r   <= (err5 < -half5);
    hi5_r   <= (err5 >= half5);
    off5_r  <= CFG_W'(sum5);
    meta6_r <= meta5_r;
    lo6_r   <= lo5_r;
    hi6_r   <= hi5_r;
    num6_r  <= NUM_W'(off5_r) * NUM_W'(pbs_pkg::SLOT_COUNT - 1);
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      quo_r[k]  <= quo_nxt[k];
      meta_r[k] <= (k == 0) ? meta6_r : meta_r[(k == 0) ? 0 : k - 1];
      lo_r[k]   <= (k == 0) ? lo6_r   : lo_r[(k == 0) ? 0 : k - 1];
      hi_r[k]   <= (k == 0) ? hi6_r   : hi_r[(k == 0) ? 0 : k - 1];
    end
  end

  // Final drive level into the queue.
  always_comb begin
    push      = dv_r[QUO_W-1];
    push_data = meta_r[QUO_W-1];
    if (lo_r[QUO_W-1]) begin
      push_data.drive = '0;
    end else if (hi_r[QUO_W-1]) begin
      push_data.drive = DRIVE_W'(pbs_pkg::SLOT_COUNT);
    end else begin
      push_data.drive = DRIVE_W'(quo_r[QUO_W-1]) + DRIVE_W'(1);
    end
  end

endmodule

// ===== rtl/pbs_fifo.sv =====
`timescale 1ns / 1ps

module pbs_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pbs_pkg::entry_t  push_data,
  input  logic             pop,
  output logic             empty,
  output pbs_pkg::entry_t  pop_data
);

  localparam int PTR_W = pbs_pkg::PTR_W;
  localparam int CNT_W = pbs_pkg::CNT_W;

  pbs_pkg::entry_t  mem_r [pbs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count updates; the front never pushes into a full queue.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(pbs_pkg::FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(pbs_pkg::FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/pbs_back.sv =====
`timescale 1ns / 1ps

module pbs_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 empty,
  input  pbs_pkg::entry_t                      pop_data,
  output logic                                 pop,
  output logic                                 out_strobe,
  output logic                                 out_slot_on,
  output logic [pbs_pkg::SLOT_W-1:0]           out_slot_index,
  output logic                                 out_last_slot,
  output logic [pbs_pkg::PCT_W-1:0]            out_level_percent,
  output logic [pbs_pkg::TENTH_W-1:0]          out_level_tenth,
  output logic signed [pbs_pkg::ERR_W-1:0]     out_control_error
);

  localparam int SLOT_W  = pbs_pkg::SLOT_W;
  localparam int DRIVE_W = pbs_pkg::DRIVE_W;

  logic              active_r, active_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  pbs_pkg::entry_t   cur_r;
  logic              at_last;

  assign at_last = active_r && (slot_r == SLOT_W'(pbs_pkg::SLOT_COUNT - 1));
  assign pop     = (!active_r || at_last) && !empty;

  // Slot sequencer: a waiting item starts right after the last slot.
  always_comb begin
    active_nxt = active_r;
    slot_nxt   = slot_r;
    if (pop) begin
      active_nxt = 1'b1;
      slot_nxt   = '0;
    end else if (at_last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= '0;
    end else begin
      active_r <= active_nxt;
      slot_r   <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
  end

  // Result fields straight from the sequencer registers.
  assign out_strobe        = active_r;
  assign out_slot_on       = (DRIVE_W'(slot_r) < cur_r.drive);
  assign out_slot_index    = slot_r;
  assign out_last_slot     = at_last;
  assign out_level_percent = cur_r.pct;
  assign out_level_tenth   = cur_r.tenth;
  assign out_control_error = cur_r.err;

endmodule
